// ----- sv/fence_completion_tracker_top_assert.svh -----
// Assertion macros shared by the fence completion tracker modules.
`ifndef FENCE_COMPLETION_TRACKER_TOP_ASSERT_SVH
`define FENCE_COMPLETION_TRACKER_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fence tracker check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fence tracker check failed");

`endif

// ----- sv/fct_pkg.sv -----
// Shared constants, codes and types of the fence completion tracker.
`default_nettype none

package fct_pkg;

  localparam int CAPACITY     = 8;
  localparam int CHANNEL_BITS = 8;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int OP_W        = 3;
  localparam int CH_PORT_W   = 8;
  localparam int VAL_W       = 64;
  localparam int RIDX_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 4;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_RETIRE = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PENDING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  typedef enum logic [2:0] {
    K_NOP,
    K_ADD,
    K_RETIRE,
    K_QUERY,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [CHANNEL_BITS-1:0] ch;
    logic [VAL_W-1:0]        val;
    logic [RIDX_W-1:0]       idx;
  } item_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] ch;
    logic [VAL_W-1:0]        val;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_MOVE,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- sv/fence_completion_tracker_top.sv -----
// Fence completion tracker: per-channel table of pending fence values.
//
// Input channel (in_valid / in_stall) carries op, channel_id, fence_value and
// read_index; a transfer happens on a clock edge with in_valid high and
// in_stall low. Every input transfer yields exactly one result transfer on
// the output channel (out_valid / out_stall) with status, out_channel,
// out_value and entry_count, in input order.
// A two-entry queue sits between the classifying front end and the table
// engine. Query, clear, channel-zero adds and retires, out-of-range reads,
// retires of an absent channel and adds that append or find the table full
// finish in the idle state; adds that merge, reads and retires that find
// the entry and either keep it or drop the last entry first read the slot
// RAM and finish in the compare state; a retire that moves the last entry
// into the freed slot also reads that entry and writes it in the move state.
// Each input is first registered in the queue; out_valid is registered too.
// A synchronous reset empties the table and the queue; slot contents are not
// cleared. While out_stall holds a result, the engine still finishes the next
// item and parks its result, and the queue keeps accepting until it is full.
`default_nettype none

module fence_completion_tracker_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [fct_pkg::OP_W-1:0]           op,
  input  wire logic [fct_pkg::CH_PORT_W-1:0]      channel_id,
  input  wire logic [fct_pkg::VAL_W-1:0]          fence_value,
  input  wire logic [fct_pkg::RIDX_W-1:0]         read_index,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [fct_pkg::STATUS_W-1:0]            status,
  output logic [fct_pkg::CH_PORT_W-1:0]           out_channel,
  output logic [fct_pkg::VAL_W-1:0]               out_value,
  output logic [fct_pkg::COUNT_OUT_W-1:0]         entry_count
);

  fct_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  fct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .channel_id  (channel_id),
    .fence_value (fence_value),
    .read_index  (read_index),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  fct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_channel (out_channel),
    .out_value   (out_value),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

// ----- sv/fct_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module fct_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/fct_front.sv -----
// Front end: classifies incoming operations and queues them for the back end.
`default_nettype none
`include "fence_completion_tracker_top_assert.svh"

module fct_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [fct_pkg::OP_W-1:0]         op,
  input  wire logic [fct_pkg::CH_PORT_W-1:0]    channel_id,
  input  wire logic [fct_pkg::VAL_W-1:0]        fence_value,
  input  wire logic [fct_pkg::RIDX_W-1:0]       read_index,
  output fct_pkg::item_t                        head,
  output logic                                  head_valid,
  input  wire logic                             pop
);

  fct_pkg::item_t                    q [fct_pkg::Q_DEPTH];
  logic [fct_pkg::QPTR_W-1:0]        wptr;
  logic [fct_pkg::QPTR_W-1:0]        rptr;
  logic [fct_pkg::QCNT_W-1:0]        cnt;
  fct_pkg::item_t                    item;
  logic [fct_pkg::CHANNEL_BITS-1:0]  ch;
  logic                              push;
  logic                              do_pop;

  assign ch = fct_pkg::CHANNEL_BITS'(channel_id);

  // Adds and retires of channel zero leave the table alone, so they are
  // turned into no-ops here and the back end only answers them with a result.
  always_comb begin
    item.ch  = ch;
    item.val = fence_value;
    item.idx = read_index;
    unique case (op)
      fct_pkg::OP_ADD:    item.kind = (ch == '0) ? fct_pkg::K_NOP : fct_pkg::K_ADD;
      fct_pkg::OP_RETIRE: item.kind = (ch == '0) ? fct_pkg::K_NOP : fct_pkg::K_RETIRE;
      fct_pkg::OP_QUERY:  item.kind = fct_pkg::K_QUERY;
      fct_pkg::OP_CLEAR:  item.kind = fct_pkg::K_CLEAR;
      fct_pkg::OP_READ:   item.kind = fct_pkg::K_READ;
      default:            item.kind = fct_pkg::K_NOP;
    endcase
  end

  assign in_stall   = (cnt == fct_pkg::QCNT_W'(fct_pkg::Q_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (cnt != '0);
  assign do_pop     = pop && head_valid;
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == fct_pkg::QPTR_W'(fct_pkg::Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == fct_pkg::QPTR_W'(fct_pkg::Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= item;
    end
  end

  `FCT_ASSERT_NOW(a_pop_needs_item, pop, head_valid)
  `FCT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= fct_pkg::QCNT_W'(fct_pkg::Q_DEPTH))
  `FCT_ASSERT_NEXT(a_cnt_grows, push && !do_pop, cnt == $past(cnt) + 1'b1)

endmodule

`default_nettype wire

// ----- sv/fct_back.sv -----
// Back end: matches channels, updates the entry table and drives results.
`default_nettype none
`include "fence_completion_tracker_top_assert.svh"

module fct_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire fct_pkg::item_t                     head,
  input  wire logic                               head_valid,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [fct_pkg::STATUS_W-1:0]            status,
  output logic [fct_pkg::CH_PORT_W-1:0]           out_channel,
  output logic [fct_pkg::VAL_W-1:0]               out_value,
  output logic [fct_pkg::COUNT_OUT_W-1:0]         entry_count
);

  localparam int IDX_W = fct_pkg::IDX_W;
  localparam int CNT_W = fct_pkg::CNT_W;

  fct_pkg::state_t                   state;
  fct_pkg::state_t                   state_next;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  count_next;
  fct_pkg::item_t                    w;
  logic [IDX_W-1:0]                  pos;
  logic [IDX_W-1:0]                  pos_next;
  logic [IDX_W-1:0]                  last;

  // Channel copies for the parallel match; the RAM holds channel and value.
  logic [fct_pkg::CHANNEL_BITS-1:0]  chan [fct_pkg::CAPACITY];
  logic                              chan_we;
  logic [IDX_W-1:0]                  chan_waddr;
  logic [fct_pkg::CHANNEL_BITS-1:0]  chan_wdata;

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr;
  fct_pkg::slot_t                    ram_wdata;
  logic [IDX_W-1:0]                  ram_raddr;
  fct_pkg::slot_t                    ram_rdata;

  logic [fct_pkg::CAPACITY-1:0]      hit_vec;
  logic                              hit;
  logic [IDX_W-1:0]                  hit_pos;
  logic                              read_ok;

  logic                              out_free;
  logic                              load_work;
  logic                              finish;
  logic                              load_out;
  logic                              save_pend;
  logic [fct_pkg::STATUS_W-1:0]      res_status;
  logic [fct_pkg::CHANNEL_BITS-1:0]  res_ch;
  logic [fct_pkg::VAL_W-1:0]         res_val;
  logic [fct_pkg::STATUS_W-1:0]      pend_status;
  logic [fct_pkg::CHANNEL_BITS-1:0]  pend_ch;
  logic [fct_pkg::VAL_W-1:0]         pend_val;
  logic [CNT_W-1:0]                  pend_count;
  logic [fct_pkg::STATUS_W-1:0]      src_status;
  logic [fct_pkg::CHANNEL_BITS-1:0]  src_ch;
  logic [fct_pkg::VAL_W-1:0]         src_val;
  logic [CNT_W-1:0]                  src_count;

  fct_ram #(
    .WIDTH ($bits(fct_pkg::slot_t)),
    .DEPTH (fct_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < fct_pkg::CAPACITY; i++) begin
      hit_vec[i] = (CNT_W'(i) < count) && (chan[i] == head.ch);
    end
  end

  // Channels are unique in the table, so at most one bit of hit_vec is set.
  always_comb begin
    hit_pos = '0;
    for (int i = fct_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
  end

  assign hit      = |hit_vec;
  assign read_ok  = (8'(head.idx) < 8'(count));
  assign last     = IDX_W'(count - 1'b1);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    pop        = 1'b0;
    load_work  = 1'b0;
    finish     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = '{ch: w.ch, val: w.val};
    ram_raddr  = pos;
    chan_we    = 1'b0;
    chan_waddr = pos;
    chan_wdata = ram_rdata.ch;
    res_status = fct_pkg::ST_OK;
    res_ch     = '0;
    res_val    = '0;
    unique case (state)
      fct_pkg::S_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          load_work = 1'b1;
          pos_next  = hit_pos;
          unique case (head.kind)
            fct_pkg::K_ADD: begin
              if (hit) begin
                ram_raddr  = hit_pos;
                state_next = fct_pkg::S_CMP;
              end else if (count < CNT_W'(fct_pkg::CAPACITY)) begin
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(count);
                ram_wdata  = '{ch: head.ch, val: head.val};
                chan_we    = 1'b1;
                chan_waddr = IDX_W'(count);
                chan_wdata = head.ch;
                count_next = count + 1'b1;
                finish     = 1'b1;
              end else begin
                res_status = fct_pkg::ST_FULL;
                finish     = 1'b1;
              end
            end
            fct_pkg::K_RETIRE: begin
              if (hit) begin
                ram_raddr  = hit_pos;
                state_next = fct_pkg::S_CMP;
              end else begin
                finish = 1'b1;
              end
            end
            fct_pkg::K_QUERY: begin
              res_status = (count == '0) ? fct_pkg::ST_OK : fct_pkg::ST_PENDING;
              finish     = 1'b1;
            end
            fct_pkg::K_CLEAR: begin
              count_next = '0;
              finish     = 1'b1;
            end
            fct_pkg::K_READ: begin
              if (read_ok) begin
                ram_raddr  = IDX_W'(head.idx);
                state_next = fct_pkg::S_CMP;
              end else begin
                res_status = fct_pkg::ST_RANGE;
                finish     = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      fct_pkg::S_CMP: begin
        unique case (w.kind)
          fct_pkg::K_ADD: begin
            if (w.val > ram_rdata.val) begin
              ram_we = 1'b1;
            end
            finish = 1'b1;
          end
          fct_pkg::K_RETIRE: begin
            if (ram_rdata.val <= w.val) begin
              if (pos == last) begin
                count_next = count - 1'b1;
                finish     = 1'b1;
              end else begin
                // The last entry fills the hole; fetch it first.
                ram_raddr  = last;
                state_next = fct_pkg::S_MOVE;
              end
            end else begin
              finish = 1'b1;
            end
          end
          fct_pkg::K_READ: begin
            res_ch  = ram_rdata.ch;
            res_val = ram_rdata.val;
            finish  = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      fct_pkg::S_MOVE: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        chan_we    = 1'b1;
        count_next = count - 1'b1;
        finish     = 1'b1;
      end
      fct_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = fct_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fct_pkg::S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = out_free ? fct_pkg::S_IDLE : fct_pkg::S_EMIT;
    end
  end

  assign load_out  = (finish && out_free) || (state == fct_pkg::S_EMIT && out_free);
  assign save_pend = finish && !out_free;

  always_comb begin
    if (state == fct_pkg::S_EMIT) begin
      src_status = pend_status;
      src_ch     = pend_ch;
      src_val    = pend_val;
      src_count  = pend_count;
    end else begin
      src_status = res_status;
      src_ch     = res_ch;
      src_val    = res_val;
      src_count  = count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fct_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_work) begin
      w <= head;
    end
    pos <= pos_next;
    if (chan_we) begin
      chan[chan_waddr] <= chan_wdata;
    end
    if (save_pend) begin
      pend_status <= res_status;
      pend_ch     <= res_ch;
      pend_val    <= res_val;
      pend_count  <= count_next;
    end
    if (load_out) begin
      status      <= src_status;
      out_channel <= fct_pkg::CH_PORT_W'(src_ch);
      out_value   <= src_val;
      entry_count <= fct_pkg::COUNT_OUT_W'(src_count);
    end
  end

  `FCT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(fct_pkg::CAPACITY))
  `FCT_ASSERT_NOW(a_pop_only_idle, pop, state == fct_pkg::S_IDLE)
  `FCT_ASSERT_NOW(a_move_distinct, state == fct_pkg::S_MOVE, pos != last)
  `FCT_ASSERT_NEXT(a_emit_drains, state == fct_pkg::S_EMIT && out_free, out_valid)

endmodule

`default_nettype wire
